// File: rtl/bbr_pkg.sv
// ----------------------------------------------------------------------------
// bbr_pkg: shared types and constants of the 3x3 RGB box blur
// Pixel, column and sum types, size limits, opcode and register indexes,
// and the helpers that clamp a frame size and divide a window sum by nine.
// ----------------------------------------------------------------------------
package bbr_pkg;

    // Frame size limits and the width of the size registers.
    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 2048;
    localparam int DIM_W        = 12;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // Column counter indexes a line store; the row counter must reach height + 1.
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

    // Channel, column-sum and window-sum widths.
    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int CSUM_W = CH_W + 2;
    localparam int TSUM_W = CH_W + 4;

    // Division by nine: multiply by ceil(2^16 / 9) and keep the integer part.
    // The error stays below 1/9 for every sum of nine 8-bit values.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 13;
    localparam int RECIP9      = 7282;
    localparam int PROD_W      = TSUM_W + RECIP_W;

    // Item kind carried in tuser.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pixel_t;

    // One window column: index 0 is the oldest row, index 2 the newest.
    typedef pixel_t [2:0] column_t;

    typedef struct packed {
        logic [CSUM_W-1:0] blue;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] red;
    } csum_t;

    typedef struct packed {
        logic [TSUM_W-1:0] blue;
        logic [TSUM_W-1:0] green;
        logic [TSUM_W-1:0] red;
    } tsum_t;

    // Per-item decisions that travel with an item down the pipeline.
    typedef struct packed {
        logic has_out;
        logic border;
        logic last;
    } flags_t;

    // What the position counters decide for the item at the input.
    typedef struct packed {
        logic             adv;
        logic             draining;
        logic [COL_W-1:0] col;
        flags_t           flags;
    } item_info_t;

    // A size of zero acts as one, a size above the limit acts as the limit.
    function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Truncating divide of a window sum by nine.
    function automatic logic [CH_W-1:0] div9(input logic [TSUM_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(RECIP9);
        return prod[RECIP_SHIFT +: CH_W];
    endfunction

endpackage

// File: rtl/bbr_ram.sv
// ----------------------------------------------------------------------------
// bbr_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered and holds
// while the read enable is low. A read of the address being written returns
// the old contents.
// ----------------------------------------------------------------------------
module bbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/bbr_cell.sv
// ----------------------------------------------------------------------------
// bbr_cell: one column cell of the 3x3 window
// Holds a column of three pixels and its per-channel sum, passes the column
// on to the next cell when the window shifts, and adds its sum to the
// running window total that flows along the row of cells.
// ----------------------------------------------------------------------------
module bbr_cell
    import bbr_pkg::*;
(
    input  logic    aclk,
    input  logic    shift_en,
    input  column_t col_in,
    input  tsum_t   part_in,
    output column_t col_out,
    output tsum_t   part_out
);

    column_t col_reg;
    csum_t   sum_reg;

    // Load the neighbor's column and its channel sums on a shift.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg       <= col_in;
            sum_reg.red   <= CSUM_W'(col_in[0].red) + CSUM_W'(col_in[1].red)
                           + CSUM_W'(col_in[2].red);
            sum_reg.green <= CSUM_W'(col_in[0].green) + CSUM_W'(col_in[1].green)
                           + CSUM_W'(col_in[2].green);
            sum_reg.blue  <= CSUM_W'(col_in[0].blue) + CSUM_W'(col_in[1].blue)
                           + CSUM_W'(col_in[2].blue);
        end
    end

    // Add this column to the running window total.
    always_comb begin
        part_out.red   = part_in.red   + TSUM_W'(sum_reg.red);
        part_out.green = part_in.green + TSUM_W'(sum_reg.green);
        part_out.blue  = part_in.blue  + TSUM_W'(sum_reg.blue);
    end

    assign col_out = col_reg;

endmodule

// File: rtl/bbr_ctrl.sv
// ----------------------------------------------------------------------------
// bbr_ctrl: frame size registers and raster position counters
// Tracks the input column and row, decides for the item at the input whether
// it advances the pipeline, whether it yields a result, whether that result
// is a border pixel, and whether it closes the frame.
// ----------------------------------------------------------------------------
module bbr_ctrl
    import bbr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_wdata,
    input  logic             item_op,
    input  logic             take,
    output item_info_t       info
);

    logic [DIM_W-1:0] width_reg,  width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [COL_W-1:0] col_reg,    col_next;
    logic [ROW_W-1:0] row_reg,    row_next;

    logic [DIM_W-1:0] col_ext;
    logic [DIM_W-1:0] col_inc;
    logic [ROW_W-1:0] crow;
    logic [DIM_W-1:0] ccol;
    logic [ROW_W-1:0] h_last;
    logic [DIM_W-1:0] w_last;
    logic             wrap;

    // Position decode for the item at the input.
    always_comb begin
        col_ext = DIM_W'(col_reg);
        col_inc = col_ext + DIM_W'(1);
        wrap    = col_inc >= width_reg;
        h_last  = ROW_W'(height_reg) - ROW_W'(1);
        w_last  = width_reg - DIM_W'(1);

        if (col_reg == '0) begin
            crow = row_reg - ROW_W'(2);
            ccol = w_last;
        end else begin
            crow = row_reg - ROW_W'(1);
            ccol = col_ext - DIM_W'(1);
        end

        info.draining      = row_reg >= ROW_W'(height_reg);
        info.adv           = !(item_op == OP_FLUSH && !info.draining);
        info.col           = col_reg;
        info.flags.has_out = (row_reg >= ROW_W'(2))
                          || (row_reg == ROW_W'(1) && col_reg != '0);
        info.flags.border  = (crow == '0) || (crow >= h_last)
                          || (ccol == '0) || (ccol >= w_last);
        info.flags.last    = info.flags.has_out && (crow == h_last) && (ccol == w_last);
    end

    // Next values of the size registers and counters.
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FRAME_WIDTH: begin
                    width_next = eff_size(cfg_wdata, DIM_W'(MAX_WIDTH));
                end
                CFG_FRAME_HEIGHT: begin
                    height_next = eff_size(cfg_wdata, DIM_W'(MAX_HEIGHT));
                end
            endcase
            col_next = '0;
            row_next = '0;
        end else if (take && info.adv) begin
            if (info.flags.last) begin
                col_next = '0;
                row_next = '0;
            end else if (wrap) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(WIDTH_RESET);
            height_reg <= DIM_W'(HEIGHT_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

// File: rtl/box_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb: streaming 3x3 mean filter on 24-bit RGB pixels
// Pixels enter in raster order on the s_ channel; filtered pixels leave on
// the m_ channel. Interior pixels get the per-channel mean of their 3x3
// neighborhood, truncated; pixels of the first or last row or column pass
// through unchanged.
//
// Usage: set frame_width and frame_height on the cfg port while the block is
// idle (a write also restarts the frame). Send the frame's pixels with
// tuser = 0, then flush transfers (tuser = 1) until the result with tlast
// set has been taken; a pixel sent after the frame's last pixel counts as a
// flush and its data is dropped, a flush sent mid-frame is taken and ignored.
// The result for a pixel is produced by the transfer width + 1 transfers
// after it, and passes the line store read, window shift, window sum, then divide
// and output register before it leaves on m_tvalid. Throughput is one transfer
// per cycle unless the receiver stalls, set by the line stores, which take one
// read and one write per cycle, and the window cells that shift once per transfer.
// Reset sets the size to 640 x 480 and restarts the frame; the line stores
// are not cleared. When the receiver stalls, the output holds its result and
// the pipeline keeps taking transfers until all of its stages are full.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb
    import bbr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // Configuration write port.
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_wdata,
    // Input stream.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PIX_W-1:0] s_tdata,   // red_in, green_in, blue_in
    input  logic             s_tuser,   // op
    // Result stream.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata,   // red_out, green_out, blue_out
    output logic             m_tlast    // frame_last
);

    item_info_t info;
    logic       take;
    logic       load1;
    logic       move1, move2, move3;
    logic       free1, free2, free3, out_free;

    // Stage 1: line store read in flight.
    logic             v1_reg, v1_next;
    pixel_t           px1_reg;
    logic [COL_W-1:0] col1_reg;
    flags_t           flags1_reg;
    logic             hit1_reg;
    pixel_t           byp_up1_reg;
    pixel_t           byp_mid1_reg;
    pixel_t           ram_up_rd;
    pixel_t           ram_mid_rd;
    pixel_t           up1;
    pixel_t           mid1;
    pixel_t           px_in;

    // Stage 2: window just shifted.
    logic   v2_reg, v2_next;
    flags_t flags2_reg;

    // Stage 3: window sum registered.
    logic   v3_reg, v3_next;
    tsum_t  tot3_reg;
    pixel_t ctr3_reg;
    logic   border3_reg;
    logic   last3_reg;

    // Output register.
    logic   m_valid_reg, m_valid_next;
    pixel_t m_pix_reg;
    logic   m_last_reg;

    // Window cell chain; index 3 is the column entering the window.
    column_t col_link  [4];
    tsum_t   part_link [4];
    pixel_t  res_pix;

    bbr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item_op   (s_tuser),
        .take      (take),
        .info      (info)
    );

    // Pipeline flow: a stage moves on when the next one is free or moving.
    always_comb begin
        out_free = !m_valid_reg || m_tready;
        move3    = v3_reg && out_free;
        free3    = !v3_reg || out_free;
        move2    = v2_reg && (!flags2_reg.has_out || free3);
        free2    = !v2_reg || move2;
        move1    = v1_reg && free2;
        free1    = !v1_reg || move1;
        s_tready = free1;
        take     = s_tvalid && free1;
        load1    = take && info.adv;
    end

    // Valid bits of the stages.
    always_comb begin
        v1_next = v1_reg;
        if (load1) begin
            v1_next = 1'b1;
        end else if (move1) begin
            v1_next = 1'b0;
        end

        v2_next = v2_reg;
        if (move1) begin
            v2_next = 1'b1;
        end else if (move2) begin
            v2_next = 1'b0;
        end

        v3_next = v3_reg;
        if (move2 && flags2_reg.has_out) begin
            v3_next = 1'b1;
        end else if (move3) begin
            v3_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (move3) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Incoming pixel; a drain transfer shifts in black.
    always_comb begin
        px_in.red   = s_tdata[CH_W-1:0];
        px_in.green = s_tdata[2*CH_W-1:CH_W];
        px_in.blue  = s_tdata[3*CH_W-1:2*CH_W];
        if (info.draining) begin
            px_in = '0;
        end
    end

    // Line store data, with the value written in the same cycle as the read
    // forwarded when a one-pixel row hits the same address back to back.
    always_comb begin
        up1  = hit1_reg ? byp_up1_reg  : ram_up_rd;
        mid1 = hit1_reg ? byp_mid1_reg : ram_mid_rd;
    end

    // Stage 1 capture.
    always_ff @(posedge aclk) begin
        if (load1) begin
            px1_reg      <= px_in;
            col1_reg     <= info.col;
            flags1_reg   <= info.flags;
            hit1_reg     <= move1 && (col1_reg == info.col);
            byp_up1_reg  <= mid1;
            byp_mid1_reg <= px1_reg;
        end
    end

    // Upper store receives the middle row, middle store the new pixel.
    bbr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .aclk    (aclk),
        .wr_en   (move1),
        .wr_addr (col1_reg),
        .wr_data (mid1),
        .rd_en   (load1),
        .rd_addr (info.col),
        .rd_data (ram_up_rd)
    );

    bbr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .aclk    (aclk),
        .wr_en   (move1),
        .wr_addr (col1_reg),
        .wr_data (px1_reg),
        .rd_en   (load1),
        .rd_addr (info.col),
        .rd_data (ram_mid_rd)
    );

    // Window: three column cells shifting toward index 0.
    always_comb begin
        col_link[3][0] = up1;
        col_link[3][1] = mid1;
        col_link[3][2] = px1_reg;
        part_link[3]   = '0;
    end

    for (genvar k = 0; k < 3; k++) begin : g_cell
        bbr_cell u_cell (
            .aclk     (aclk),
            .shift_en (move1),
            .col_in   (col_link[k+1]),
            .part_in  (part_link[k+1]),
            .col_out  (col_link[k]),
            .part_out (part_link[k])
        );
    end

    // Stage 2 flags follow the item into the window.
    always_ff @(posedge aclk) begin
        if (move1) begin
            flags2_reg <= flags1_reg;
        end
    end

    // Stage 3 capture of the window total and center pixel.
    always_ff @(posedge aclk) begin
        if (move2 && flags2_reg.has_out) begin
            tot3_reg    <= part_link[0];
            ctr3_reg    <= col_link[1][1];
            border3_reg <= flags2_reg.border;
            last3_reg   <= flags2_reg.last;
        end
    end

    // Mean or pass-through, then the output register.
    always_comb begin
        res_pix.red   = div9(tot3_reg.red);
        res_pix.green = div9(tot3_reg.green);
        res_pix.blue  = div9(tot3_reg.blue);
        if (border3_reg) begin
            res_pix = ctr3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (move3) begin
            m_pix_reg  <= res_pix;
            m_last_reg <= last3_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pix_reg.blue, m_pix_reg.green, m_pix_reg.red};
    assign m_tlast  = m_last_reg;

endmodule
